[rtl/quad_edge_collision_test_core_assert.svh]
// Assertion macros used by the quad edge collision test RTL.
`ifndef QUAD_EDGE_COLLISION_TEST_CORE_ASSERT_SVH
`define QUAD_EDGE_COLLISION_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define QECT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quad edge collision check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define QECT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quad edge collision check failed");

`endif

[rtl/qect_pkg.sv]
// Package with constants, types and functions of the quad edge collision test.
`default_nettype none
package qect_pkg;
  localparam int CW     = 16;          // coordinate width
  localparam int NCORN  = 4;           // corners per quadrilateral
  localparam int NREG   = 2 * NCORN;   // configuration registers
  localparam int NPAIR  = NCORN * NCORN;
  localparam int NLANE  = 4 * NPAIR;   // orientation lanes
  localparam int IN_W   = ((NREG * CW + 7) / 8) * 8;
  localparam int OUT_W  = 8;
  localparam int IDX_W  = $clog2(NREG);
  localparam int EDGE_W = $clog2(NCORN);

  // Orientation code of an ordered point triple.
  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_t;

  // Pipeline enable and stage valid flags.
  typedef struct packed {
    logic       en;
    logic [2:0] vld;
  } pipe_ctl_t;

  // Point q within the bounding box of p and r.
  function automatic logic in_box(input logic signed [CW-1:0] px, py, qx, qy, rx, ry);
    logic okx, oky;
    begin
      okx = ((px <= qx) && (qx <= rx)) || ((rx <= qx) && (qx <= px));
      oky = ((py <= qy) && (qy <= ry)) || ((ry <= qy) && (qy <= py));
      in_box = okx && oky;
    end
  endfunction

  // Segment contact from four orientation codes and four on-box flags.
  function automatic logic touch(input orient_t o0, o1, o2, o3, input logic [3:0] w);
    begin
      touch = ((o0 != o1) && (o2 != o3)) ||
              ((o0 == ORI_COL) && w[0]) || ((o1 == ORI_COL) && w[1]) ||
              ((o2 == ORI_COL) && w[2]) || ((o3 == ORI_COL) && w[3]);
    end
  endfunction
endpackage
`default_nettype wire

[rtl/qect_orient_lane.sv]
// Three-stage orientation lane: differences, products, sign of the cross term.
`default_nettype none
module qect_orient_lane
  import qect_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  input  wire logic signed [CW-1:0] qx,
  input  wire logic signed [CW-1:0] qy,
  input  wire logic signed [CW-1:0] rx,
  input  wire logic signed [CW-1:0] ry,
  output orient_t                   code
);
  logic signed [CW:0]     d1_r, d2_r, d3_r, d4_r;
  logic signed [2*CW+1:0] m1_r, m2_r;
  logic signed [2*CW+2:0] v_nxt;
  orient_t                code_r;

  // Stage one: edge and offset differences.
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= {qy[CW-1], qy} - {py[CW-1], py};
      d2_r <= {rx[CW-1], rx} - {qx[CW-1], qx};
      d3_r <= {qx[CW-1], qx} - {px[CW-1], px};
      d4_r <= {ry[CW-1], ry} - {qy[CW-1], qy};
    end
  end

  // Stage two: the two products of the cross term.
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= d1_r * d2_r;
      m2_r <= d3_r * d4_r;
    end
  end

  // Stage three: subtract and classify the sign.
  assign v_nxt = {m1_r[2*CW+1], m1_r} - {m2_r[2*CW+1], m2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_nxt == '0) begin
        code_r <= ORI_COL;
      end else if (v_nxt[2*CW+2]) begin
        code_r <= ORI_CCW;
      end else begin
        code_r <= ORI_CW;
      end
    end
  end

  assign code = code_r;
endmodule
`default_nettype wire

[rtl/qect_select.sv]
// Contact decision per edge pair and first-pair priority encoder.
`default_nettype none
module qect_select
  import qect_pkg::*;
(
  input  wire logic [2*NLANE-1:0] codes,
  input  wire logic [NLANE-1:0]   wins,
  output logic                    hit,
  output logic [EDGE_W-1:0]       ref_edge,
  output logic [EDGE_W-1:0]       cand_edge
);
  logic [NPAIR-1:0] pair_hit;

  // Contact test of each pair from its four lanes.
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      pair_hit[p] = touch(orient_t'(codes[(4*p+0)*2 +: 2]), orient_t'(codes[(4*p+1)*2 +: 2]),
                          orient_t'(codes[(4*p+2)*2 +: 2]), orient_t'(codes[(4*p+3)*2 +: 2]),
                          wins[4*p +: 4]);
    end
  end

  // Lowest pair index wins: reference edge first, then candidate edge.
  always_comb begin
    hit       = 1'b0;
    ref_edge  = '0;
    cand_edge = '0;
    for (int p = NPAIR - 1; p >= 0; p--) begin
      if (pair_hit[p]) begin
        hit       = 1'b1;
        ref_edge  = EDGE_W'(p / NCORN);
        cand_edge = EDGE_W'(p % NCORN);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/quad_edge_collision_test_core.sv]
// An accepted word passes the three register stages of the 64 orientation lanes and then
// the output register before its result shows on out_tdata. One word per cycle while the
// pipeline advances; the whole pipeline holds while out_tvalid is high and out_tready is low.
// Reset: synchronous active-low rst_n clears all valid bits and sets the reference
// corners to zero.
`default_nettype none
module quad_edge_collision_test_core
  import qect_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // cand_ax, cand_ay, cand_bx, cand_by, cand_cx, cand_cy, cand_dx, cand_dy
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // collides, hit_ref_edge, hit_cand_edge, zero padding
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CW-1:0]    cfg_wdata
);
  logic [CW-1:0]          ref_r [NREG];
  logic signed [CW-1:0]   rx [NCORN], ry [NCORN], cx [NCORN], cy [NCORN];
  pipe_ctl_t              ctl;
  logic [2:0]             vld_r;
  logic                   out_vld_r;
  logic [OUT_W-1:0]       out_data_r;
  logic [NLANE-1:0]       win_nxt, win1_r, win2_r, win3_r;
  logic [2*NLANE-1:0]     codes;
  logic                   hit;
  logic [EDGE_W-1:0]      ref_edge, cand_edge;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NREG; k++) ref_r[k] <= '0;
    end else if (cfg_we) begin
      ref_r[cfg_index] <= cfg_wdata;
    end
  end

  // Corner coordinates of both shapes.
  always_comb begin
    for (int k = 0; k < NCORN; k++) begin
      rx[k] = ref_r[2*k];
      ry[k] = ref_r[2*k+1];
      cx[k] = in_tdata[(2*k)*CW +: CW];
      cy[k] = in_tdata[(2*k+1)*CW +: CW];
    end
  end

  // The whole pipeline advances unless a result waits at a stalled output.
  assign ctl.en    = !(out_vld_r && !out_tready);
  assign ctl.vld   = vld_r;
  assign in_tready = ctl.en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r     <= {vld_r[1:0], in_tvalid};
      out_vld_r <= vld_r[2];
    end
  end

  // Orientation lanes and bounding-box flags for each edge pair.
  for (genvar i = 0; i < NCORN; i++) begin : g_ref
    for (genvar j = 0; j < NCORN; j++) begin : g_cand
      localparam int P  = i * NCORN + j;
      localparam int I1 = (i + 1) % NCORN;
      localparam int J1 = (j + 1) % NCORN;
      orient_t o0, o1, o2, o3;

      qect_orient_lane u_o0 (.clk, .en(ctl.en), .px(rx[i]), .py(ry[i]), .qx(rx[I1]),
                             .qy(ry[I1]), .rx(cx[j]), .ry(cy[j]), .code(o0));
      qect_orient_lane u_o1 (.clk, .en(ctl.en), .px(rx[i]), .py(ry[i]), .qx(rx[I1]),
                             .qy(ry[I1]), .rx(cx[J1]), .ry(cy[J1]), .code(o1));
      qect_orient_lane u_o2 (.clk, .en(ctl.en), .px(cx[j]), .py(cy[j]), .qx(cx[J1]),
                             .qy(cy[J1]), .rx(rx[i]), .ry(ry[i]), .code(o2));
      qect_orient_lane u_o3 (.clk, .en(ctl.en), .px(cx[j]), .py(cy[j]), .qx(cx[J1]),
                             .qy(cy[J1]), .rx(rx[I1]), .ry(ry[I1]), .code(o3));

      assign codes[(4*P)*2 +: 8] = {o3, o2, o1, o0};

      assign win_nxt[4*P+0] = in_box(rx[i], ry[i], cx[j], cy[j], rx[I1], ry[I1]);
      assign win_nxt[4*P+1] = in_box(rx[i], ry[i], cx[J1], cy[J1], rx[I1], ry[I1]);
      assign win_nxt[4*P+2] = in_box(cx[j], cy[j], rx[i], ry[i], cx[J1], cy[J1]);
      assign win_nxt[4*P+3] = in_box(cx[j], cy[j], rx[I1], ry[I1], cx[J1], cy[J1]);
    end
  end

  // Bounding-box flags travel alongside the lane stages.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      win1_r <= win_nxt;
      win2_r <= win1_r;
      win3_r <= win2_r;
    end
  end

  qect_select u_select (
    .codes     (codes),
    .wins      (win3_r),
    .hit       (hit),
    .ref_edge  (ref_edge),
    .cand_edge (cand_edge)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      out_data_r <= OUT_W'({cand_edge, ref_edge, hit});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`include "quad_edge_collision_test_core_assert.svh"

  `QECT_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0])
  `QECT_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[4:1] == 4'd0)
  `QECT_ASSERT_NEXT(a_stall_holds, !ctl.en, ctl.vld == $past(ctl.vld) && out_tvalid)
endmodule
`default_nettype wire

[sim/quad_edge_collision_test_core_tb.sv]
// Testbench for the quad edge collision test core: self-checking scoreboard with random stimulus.
`timescale 1ns / 100ps
`default_nettype none
module quad_edge_collision_test_core_tb;
  import qect_pkg::*;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    logic       collides;
    logic [1:0] ref_edge;
    logic [1:0] cand_edge;
  } contact_t;

  // Scoreboard: holds the reference shape and the queue of expected contacts.
  class contact_board;
    coord_t   ref_shape[NREG];
    contact_t pending[$];
    int       errors;

    function void set_reg(int idx, coord_t val);
      if (idx < NREG) ref_shape[idx] = val;
    endfunction

    function automatic int orientation(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
      longint v;
      v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (v == 0) return 0;
      return (v > 0) ? 1 : 2;
    endfunction

    function automatic bit on_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
      return ((qx <= px && qx >= rx) || (qx <= rx && qx >= px)) &&
             ((qy <= py && qy >= ry) || (qy <= ry && qy >= py));
    endfunction

    function automatic bit segments_touch(longint ax, longint ay, longint bx, longint by,
                                          longint cx, longint cy, longint dx, longint dy);
      int o0, o1, o2, o3;
      o0 = orientation(ax, ay, bx, by, cx, cy);
      o1 = orientation(ax, ay, bx, by, dx, dy);
      o2 = orientation(cx, cy, dx, dy, ax, ay);
      o3 = orientation(cx, cy, dx, dy, bx, by);
      if (o0 != o1 && o2 != o3) return 1;
      if (o0 == 0 && on_box(ax, ay, cx, cy, bx, by)) return 1;
      if (o1 == 0 && on_box(ax, ay, dx, dy, bx, by)) return 1;
      if (o2 == 0 && on_box(cx, cy, ax, ay, dx, dy)) return 1;
      if (o3 == 0 && on_box(cx, cy, bx, by, dx, dy)) return 1;
      return 0;
    endfunction

    // Predict the first touching edge pair for an accepted word.
    function void note_input(logic [IN_W-1:0] word);
      coord_t   c[NREG];
      contact_t r;
      int       i1, j1;
      bit       found;
      for (int k = 0; k < NREG; k++) c[k] = word[k*CW +: CW];
      r = '{1'b0, 2'd0, 2'd0};
      found = 0;
      for (int i = 0; i < NCORN && !found; i++) begin
        i1 = (i + 1) % NCORN;
        for (int j = 0; j < NCORN && !found; j++) begin
          j1 = (j + 1) % NCORN;
          if (segments_touch(ref_shape[2*i], ref_shape[2*i+1], ref_shape[2*i1],
                             ref_shape[2*i1+1], c[2*j], c[2*j+1], c[2*j1],
                             c[2*j1+1])) begin
            r = '{1'b1, 2'(i), 2'(j)};
            found = 1;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      contact_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", word);
        return;
      end
      e = pending.pop_front();
      if (word[0] !== e.collides || word[2:1] !== e.ref_edge ||
          word[4:3] !== e.cand_edge || word[7:5] !== 3'd0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit=%0d ref=%0d cand=%0d, got %h",
                   e.collides, e.ref_edge, e.cand_edge, word);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]    cfg_wdata = '0;

  contact_board board = new();
  int  idle_pct = 37;
  bit  hold_off = 0;
  bit  stim_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quad_edge_collision_test_core i_dut (.*);

  // Note each word as it is accepted and check each result as it is taken.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic write_reg(int idx, coord_t val);
    cfg_we    <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Offer one word, idling at random first, and hold it until accepted.
  task automatic send_word(logic [IN_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_quad(coord_t c[NREG]);
    logic [IN_W-1:0] w;
    w = '0;
    for (int k = 0; k < NREG; k++) w[k*CW +: CW] = c[k];
    send_word(w);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Random candidate: mostly small shapes near the reference, some full range,
  // some with shared corners or collinear points to hit the special cases.
  task automatic send_random(int span);
    coord_t c[NREG];
    int     mode;
    mode = $urandom_range(9);
    for (int k = 0; k < NREG; k++)
      c[k] = (mode == 0) ? rnd_coord(0) : rnd_coord(span);
    if (mode == 1) begin
      int r;
      r = 2 * $urandom_range(3);
      c[0] = board.ref_shape[r];
      c[1] = board.ref_shape[r+1];
    end else if (mode == 2) begin
      c[2] = c[0];
      c[3] = c[1];
    end else if (mode == 3) begin
      c[4] = c[0] + (c[2] - c[0]) * 2;
      c[5] = c[1] + (c[3] - c[1]) * 2;
    end
    send_quad(c);
  endtask

  // Write all reference registers back to back, then release the write enable.
  task automatic load_ref(coord_t r[NREG]);
    for (int k = 0; k < NREG; k++) write_reg(k, r[k]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    coord_t q[NREG];
    coord_t rs[NREG];
    int     span;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default zero reference, a 100 by 100 square with typical cases, then a full-range square.
    q = '{default: 0};
    send_quad(q);
    q = '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767};
    send_quad(q);
    drain();
    rs = '{0, 0, 100, 0, 100, 100, 0, 100};
    load_ref(rs);
    q = '{10, 10, 20, 10, 20, 20, 10, 20};        // contained, no contact
    send_quad(q);
    q = '{50, -50, 150, 50, 50, 150, -50, 50};    // crossing
    send_quad(q);
    q = '{100, 100, 200, 100, 200, 200, 100, 200}; // shared corner
    send_quad(q);
    q = '{50, 0, 50, 0, 50, 0, 50, 0};            // degenerate point on edge
    send_quad(q);
    q = '{200, 0, 300, 0, 300, 0, 200, 0};        // collinear, disjoint
    send_quad(q);
    q = '{50, 0, 150, 0, 150, -10, 50, -10};      // collinear overlap
    send_quad(q);
    q = '{200, 200, 300, 200, 300, 300, 200, 300}; // far apart
    send_quad(q);
    q = '{-32768, 50, 32767, 50, 32767, 51, -32768, 51};
    send_quad(q);
    drain();
    rs = '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767};
    load_ref(rs);
    q = '{-32768, -32768, -32768, -32768, 0, 0, 0, 0};
    send_quad(q);
    q = '{-1, -1, 1, 1, -1, 1, 1, -1};
    send_quad(q);
    q = '{32767, 0, 32767, 5, 32766, 5, 32766, 0};
    send_quad(q);
    drain();

    // Random phases over several reference shapes.
    for (int ph = 0; ph < 7; ph++) begin
      span = (ph == 6) ? 0 : (ph % 2 == 0 ? 200 : 4000);
      for (int k = 0; k < NREG; k++) rs[k] = rnd_coord(span);
      if (ph == 5) rs = '{default: 32767};
      load_ref(rs);
      if (ph == 2) idle_pct = 0;
      for (int n = 0; n < 250; n++) begin
        if (ph == 3 && n == 20) begin
          fork
            begin
              hold_off = 1;
              repeat (60) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_random(span);
      end
      idle_pct = 37;
      drain();
    end
    stim_done = 1;
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
